FILE: rtl/tesm_pkg.sv
// shared types, constants and pattern tables of the terminal escape sequence matcher
// used by tesm_lane, tesm_sgr and terminal_escape_sequence_matcher
package tesm_pkg;

  localparam int MAX_PATTERNS      = 64;
  localparam int MAX_SEQ_LEN       = 32;
  localparam int MAX_PATTERN_CHARS = 16;

  localparam int PAT_W   = 8 * MAX_PATTERN_CHARS;
  localparam int POS_W   = $clog2(MAX_PATTERN_CHARS + 1);
  localparam int CNT_W   = $clog2(MAX_SEQ_LEN + 2);
  localparam int IDX_W   = 7;
  localparam int LEN_W   = 6;
  localparam int TT_W    = 2;

  localparam logic [IDX_W-1:0] SGR_INDEX = IDX_W'(64);

  localparam logic [7:0] CH_ESC  = 8'd27;
  localparam logic [7:0] CH_LBR  = 8'h5b;  // '['
  localparam logic [7:0] CH_M    = 8'h6d;  // 'm'
  localparam logic [7:0] CH_SEMI = 8'h3b;  // ';'
  localparam logic [7:0] CH_PCT  = 8'h25;  // '%'
  localparam logic [7:0] CH_D    = 8'h64;  // 'd'
  localparam logic [7:0] CH_0    = 8'h30;
  localparam logic [7:0] CH_9    = 8'h39;

  typedef enum logic [1:0] {
    TT_VT100 = 2'd0,
    TT_XTERM = 2'd1,
    TT_ANSI  = 2'd2,
    TT_NONE  = 2'd3
  } term_t;

  typedef enum logic [1:0] {
    ST_PREFIX = 2'd0,
    ST_MATCH  = 2'd1,
    ST_REJECT = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    RES_DEAD   = 2'd0,
    RES_PREFIX = 2'd1,
    RES_MATCH  = 2'd2
  } res_t;

  typedef enum logic [1:0] {
    MODE_CHAR  = 2'd0,
    MODE_START = 2'd1,
    MODE_NUM   = 2'd2
  } mode_t;

  // per-byte control handed to every matcher
  typedef struct packed {
    logic       step;
    logic       clear;
    logic [7:0] data;
  } step_ctl_t;

  localparam int VT100_N = 64;
  localparam int XTERM_N = 1;
  localparam int ANSI_N  = 39;

  localparam logic [PAT_W-1:0] VT100_TAB [VT100_N] = '{
    "\007", "\0335m", "\0331m", "\033[2J", "\015", "\033[%d;%dr",
    "\033[%dD", "\010", "\033[%dB", "\012", "\033[%dC", "\033[C",
    "\033[%d;%dH", "\033[%dA", "\033[A", "\033[J", "\033[K", "\033[1K",
    "\033(B\033)0", "\033[H", "\011", "\033H", "\012", "\033Oq", "\033Os",
    "\033Or", "\010", "\033Op", "\033On", "\033OD", "\033OB", "\033OC",
    "\033OA", "\033OM", "\033Oy", "\033OP", "\033Ox", "\033OQ", "\033OR",
    "\033OS", "\033Ot", "\033Ou", "\033Ov", "\033Ol", "\033Ow",
    "\033[0i", "\033[4i", "\033[5i", "\0338", "\033[7m", "\033M", "\017",
    "\033[?7l", "\033[?1l\033>", "\033[m", "\033[m", "\0337", "\033[0m",
    "\016", "\033[?7h", "\033[?1h\033", "\0337m", "\033[4m", "\033[3g"
  };

  localparam logic [PAT_W-1:0] XTERM_TAB [XTERM_N] = '{
    "\033[%d;%dH"
  };

  localparam logic [PAT_W-1:0] ANSI_TAB [ANSI_N] = '{
    "\007", "\033[5m", "\033[1m", "\033[H\033[J", "\015", "\033%dD",
    "\033[D", "\033[%dB", "\033[B", "\033[%dC", "\033[C", "\033[%d;%dH",
    "\033%dA", "\033[A", "\033[J", "\033[1K", "\033[H", "\033[I", "\033H",
    "\012", "\033[8m", "\010", "\033[D", "\033[B", "\033[C", "\033[A",
    "\033[4i", "\033[5i", "\015\033[S", "\033[7m", "\033[10m", "\033[m",
    "\033[m", "\033[0;10m", "\033[11m", "\033[7m", "\033[4m", "\033[3g",
    "\033[%dd"
  };

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= CH_0) && (b <= CH_9);
  endfunction

  // pattern string of entry k, right aligned, zero when k is past the table
  function automatic logic [PAT_W-1:0] pat_str(input logic [TT_W-1:0] tt, input int k);
    logic [PAT_W-1:0] s;
    s = '0;
    unique case (term_t'(tt))
      TT_VT100: if (k < VT100_N) s = VT100_TAB[k];
      TT_XTERM: if (k < XTERM_N) s = XTERM_TAB[k];
      TT_ANSI:  if (k < ANSI_N)  s = ANSI_TAB[k];
      TT_NONE:  s = '0;
      default:  s = '0;
    endcase
    return s;
  endfunction

  function automatic logic [POS_W-1:0] pat_len(input logic [PAT_W-1:0] s);
    logic [POS_W-1:0] n;
    n = '0;
    for (int i = 0; i < MAX_PATTERN_CHARS; i++) begin
      if (s[i*8 +: 8] != 8'd0) n = POS_W'(i + 1);
    end
    return n;
  endfunction

  function automatic logic [7:0] pat_chr(input logic [PAT_W-1:0] s,
                                         input logic [POS_W-1:0] len,
                                         input logic [POS_W:0] pos);
    logic [7:0] c;
    c = '0;
    for (int i = 0; i < MAX_PATTERN_CHARS; i++) begin
      if ((POS_W+1)'(i) == pos && (POS_W+1)'(i) < (POS_W+1)'(len))
        c = s[(int'(len) - 1 - i)*8 +: 8];
    end
    return c;
  endfunction

endpackage

FILE: rtl/tesm_lane.sv
// one pattern table entry: position, digit mode and alive bit
// depends on tesm_pkg
module tesm_lane #(
  parameter int K = 0
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [tesm_pkg::TT_W-1:0] tt,
  input  tesm_pkg::step_ctl_t     ctl,
  output tesm_pkg::res_t          res
);

  logic [tesm_pkg::POS_W-1:0] pos_r, pos_nxt;
  tesm_pkg::mode_t            mode_r, mode_nxt;
  logic                       alive_r;

  logic [tesm_pkg::PAT_W-1:0] pat;
  logic [tesm_pkg::POS_W-1:0] len;
  logic [tesm_pkg::POS_W:0]   pos;
  tesm_pkg::mode_t            mode;
  tesm_pkg::res_t             r;
  logic                       done;
  logic [7:0]                 c;
  logic                       dig;

  assign pat = tesm_pkg::pat_str(tt, K);
  assign len = tesm_pkg::pat_len(pat);
  assign dig = tesm_pkg::is_digit(ctl.data);

  // a %d field can fall through to the next literal, so allow a few steps
  always_comb begin
    pos  = {1'b0, pos_r};
    mode = mode_r;
    r    = tesm_pkg::RES_DEAD;
    done = !alive_r;
    c    = '0;
    for (int it = 0; it < 4; it++) begin
      if (!done) begin
        if (pos >= (tesm_pkg::POS_W+1)'(len)) begin
          done = 1'b1;
        end else begin
          unique case (mode)
            tesm_pkg::MODE_CHAR: begin
              c = tesm_pkg::pat_chr(pat, len, pos);
              if (c == tesm_pkg::CH_PCT) begin
                if (pos + 1'b1 < (tesm_pkg::POS_W+1)'(len) &&
                    tesm_pkg::pat_chr(pat, len, pos + 1'b1) == tesm_pkg::CH_D)
                  mode = tesm_pkg::MODE_START;
                pos = pos + 2'd2;
              end else begin
                if (c == ctl.data) begin
                  pos = pos + 1'b1;
                  r = (pos >= (tesm_pkg::POS_W+1)'(len)) ? tesm_pkg::RES_MATCH
                                                         : tesm_pkg::RES_PREFIX;
                end
                done = 1'b1;
              end
            end
            tesm_pkg::MODE_START: begin
              if (dig) begin
                mode = tesm_pkg::MODE_NUM;
                r    = tesm_pkg::RES_PREFIX;
              end
              done = 1'b1;
            end
            tesm_pkg::MODE_NUM: begin
              if (dig) begin
                r    = tesm_pkg::RES_PREFIX;
                done = 1'b1;
              end else begin
                mode = tesm_pkg::MODE_CHAR;
              end
            end
            default: done = 1'b1;
          endcase
        end
      end
    end
    pos_nxt  = pos[tesm_pkg::POS_W-1:0];
    mode_nxt = mode;
  end

  assign res = r;

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      pos_r   <= '0;
      mode_r  <= tesm_pkg::MODE_CHAR;
      alive_r <= 1'b1;
    end else if (ctl.step) begin
      pos_r   <= pos_nxt;
      mode_r  <= mode_nxt;
      alive_r <= (r != tesm_pkg::RES_DEAD);
    end
  end

endmodule

FILE: rtl/tesm_sgr.sv
// dynamic SGR matcher: ESC [ then digits and semicolons, m right after a digit
// depends on tesm_pkg
module tesm_sgr (
  input  logic                clk,
  input  logic                rst_n,
  input  tesm_pkg::step_ctl_t ctl,
  output tesm_pkg::res_t      res
);

  typedef enum logic [1:0] {
    PH_ESC  = 2'd0,
    PH_LBR  = 2'd1,
    PH_BODY = 2'd2,
    PH_DEAD = 2'd3
  } phase_t;

  phase_t phase_r, phase_nxt;
  logic   digit_r, digit_nxt;
  logic   dig;

  assign dig = tesm_pkg::is_digit(ctl.data);

  always_comb begin
    phase_nxt = PH_DEAD;
    digit_nxt = digit_r;
    res       = tesm_pkg::RES_DEAD;
    unique case (phase_r)
      PH_ESC: begin
        if (ctl.data == tesm_pkg::CH_ESC) begin
          phase_nxt = PH_LBR;
          res       = tesm_pkg::RES_PREFIX;
        end
      end
      PH_LBR: begin
        if (ctl.data == tesm_pkg::CH_LBR) begin
          phase_nxt = PH_BODY;
          digit_nxt = 1'b0;
          res       = tesm_pkg::RES_PREFIX;
        end
      end
      PH_BODY: begin
        priority if (ctl.data == tesm_pkg::CH_M && digit_r) begin
          phase_nxt = PH_BODY;
          res       = tesm_pkg::RES_MATCH;
        end else if (dig) begin
          phase_nxt = PH_BODY;
          digit_nxt = 1'b1;
          res       = tesm_pkg::RES_PREFIX;
        end else if (ctl.data == tesm_pkg::CH_SEMI) begin
          phase_nxt = PH_BODY;
          digit_nxt = 1'b0;
          res       = tesm_pkg::RES_PREFIX;
        end else begin
          phase_nxt = PH_DEAD;
        end
      end
      PH_DEAD: phase_nxt = PH_DEAD;
      default: phase_nxt = PH_DEAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      phase_r <= PH_ESC;
      digit_r <= 1'b0;
    end else if (ctl.step) begin
      phase_r <= phase_nxt;
      digit_r <= digit_nxt;
    end
  end

endmodule

FILE: rtl/terminal_escape_sequence_matcher.sv
// top level of the terminal escape sequence matcher
// depends on tesm_pkg, tesm_lane and tesm_sgr
//
// Each byte of terminal output gives one result: still a prefix, matched (with
// the table entry, 64 for a dynamic SGR code, and the sequence length) or not an
// escape. The block takes one byte per cycle unless the output stalls, and the
// result is registered: an input register, then all 64 pattern lanes and the SGR
// matcher advance in one pass into the result register. Writing cfg_terminal_type
// selects the pattern table and restarts the current sequence.
module terminal_escape_sequence_matcher (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_status,
  output logic [6:0] out_entry_index,
  output logic [5:0] out_match_length,
  input  logic       cfg_we,
  input  logic [1:0] cfg_terminal_type
);

  localparam int NP = tesm_pkg::MAX_PATTERNS;

  logic [tesm_pkg::TT_W-1:0]  tt_r;
  logic [7:0]                 data_r;
  logic                       s1_valid_r;
  logic [tesm_pkg::CNT_W-1:0] cnt_r, cnt;
  logic                       out_valid_r;
  tesm_pkg::status_t          status_r, status_nxt;
  logic [tesm_pkg::IDX_W-1:0] idx_r, idx_nxt;
  logic [tesm_pkg::LEN_W-1:0] len_r, len_nxt;

  logic                adv, over, found, prefix, restart;
  tesm_pkg::res_t      lane_res [NP];
  tesm_pkg::res_t      sgr_res;
  tesm_pkg::step_ctl_t ctl;

  assign adv      = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || adv;

  assign cnt  = cnt_r + 1'b1;
  assign over = cnt > tesm_pkg::CNT_W'(tesm_pkg::MAX_SEQ_LEN);

  assign ctl.step  = adv && !over;
  assign ctl.clear = cfg_we || (adv && restart);
  assign ctl.data  = data_r;

  for (genvar k = 0; k < NP; k++) begin : g_lane
    tesm_lane #(.K(k)) u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .tt    (tt_r),
      .ctl   (ctl),
      .res   (lane_res[k])
    );
  end

  tesm_sgr u_sgr (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .res   (sgr_res)
  );

  // lowest table index wins, table beats sgr
  always_comb begin
    found   = 1'b0;
    prefix  = 1'b0;
    idx_nxt = '0;
    for (int k = NP - 1; k >= 0; k--) begin
      if (lane_res[k] == tesm_pkg::RES_MATCH) begin
        found   = 1'b1;
        idx_nxt = tesm_pkg::IDX_W'(k);
      end
      if (lane_res[k] == tesm_pkg::RES_PREFIX) prefix = 1'b1;
    end
    if (sgr_res == tesm_pkg::RES_PREFIX) prefix = 1'b1;
    if (!found && sgr_res == tesm_pkg::RES_MATCH) begin
      found   = 1'b1;
      idx_nxt = tesm_pkg::SGR_INDEX;
    end
    restart = over || found || !prefix;

    priority if (over) begin
      status_nxt = tesm_pkg::ST_REJECT;
    end else if (found) begin
      status_nxt = tesm_pkg::ST_MATCH;
    end else if (prefix) begin
      status_nxt = tesm_pkg::ST_PREFIX;
    end else begin
      status_nxt = tesm_pkg::ST_REJECT;
    end
    if (status_nxt != tesm_pkg::ST_MATCH) idx_nxt = '0;
    len_nxt = (status_nxt == tesm_pkg::ST_MATCH) ? tesm_pkg::LEN_W'(cnt) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tt_r        <= '0;
      s1_valid_r  <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) tt_r <= cfg_terminal_type;

      if (in_ready) s1_valid_r <= in_valid;

      if (ctl.clear) begin
        cnt_r <= '0;
      end else if (adv) begin
        cnt_r <= cnt;
      end

      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) data_r <= in_data_byte;
    if (adv) begin
      status_r <= status_nxt;
      idx_r    <= idx_nxt;
      len_r    <= len_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_entry_index  = idx_r;
  assign out_match_length = len_r;

  a_match_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && status_r == tesm_pkg::ST_MATCH |->
      len_r != '0 && len_r <= tesm_pkg::LEN_W'(tesm_pkg::MAX_SEQ_LEN))
    else $error("matched result with bad length");

  a_nomatch_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && status_r != tesm_pkg::ST_MATCH |-> idx_r == '0 && len_r == '0)
    else $error("index or length set without a match");

  a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> cnt_r == '0)
    else $error("byte count not cleared by configuration write");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= tesm_pkg::CNT_W'(tesm_pkg::MAX_SEQ_LEN))
    else $error("byte count past maximum sequence length");

endmodule
